// ===== hw/rtl/one_bit_instruction_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// One-bit instruction encoder: assertion macros
// Shared assertion shorthands, clocked on clk and muted during rst.
// ----------------------------------------------------------------------------
`ifndef ONE_BIT_INSTRUCTION_ENCODER_DEFINES_SVH
`define ONE_BIT_INSTRUCTION_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define OBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/obe_pkg.sv =====
// ----------------------------------------------------------------------------
// obe_pkg
// Types, codes and packing helpers for the one-bit instruction encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package obe_pkg;

  localparam int unsigned ActionW  = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CtlW     = 7;

  // "no input" / "no output" selector
  localparam logic [ByteW-1:0] NULL_SEL  = 8'd7;
  localparam logic [ByteW-1:0] DATA_ZERO = 8'd0;
  localparam logic [ByteW-1:0] DATA_ONE  = 8'd1;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_INPUT  = 2'd1,
    FAULT_OUTPUT = 2'd2,
    FAULT_DATA   = 2'd3
  } fault_t;

  typedef enum logic [ActionW-1:0] {
    ACT_NOP, ACT_HALT, ACT_SETB, ACT_SETBJMP, ACT_CSETB, ACT_CLRB, ACT_CLRBJMP,
    ACT_CCLRB, ACT_OUTIN, ACT_OUTINJMP, ACT_OUTV, ACT_OUTVJMP, ACT_OUT,
    ACT_OUTI, ACT_OUTIJMP, ACT_OUTJMP, ACT_COUTF, ACT_IN, ACT_INJMP, ACT_INJPS,
    ACT_INJPC, ACT_CINF, ACT_JMP, ACT_JPS, ACT_JPC, ACT_FORKF, ACT_FORKI,
    ACT_WAITIS, ACT_WAITIC, ACT_SKIPIC, ACT_SKIPIS, ACT_SKIPFC, ACT_SKIPFS,
    ACT_REPTIC, ACT_REPTIS, ACT_REPTFC, ACT_REPTFS
  } act_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [ByteW-1:0]   first_operand;
    logic [ByteW-1:0]   second_operand;
    logic [ByteW-1:0]   third_operand;
    logic [ByteW-1:0]   fourth_operand;
    logic [ByteW-1:0]   here_address;
  } instr_t;

  typedef struct packed {
    logic [CtlW-1:0]  false_control;
    logic [ByteW-1:0] false_next;
    logic [CtlW-1:0]  true_control;
    logic [ByteW-1:0] true_next;
    fault_t           fault;
  } word_t;

  // Range check of one control byte: input, then output, then data.
  function automatic fault_t ctl_check(input logic [ByteW-1:0] sel_in,
                                       input logic [ByteW-1:0] sel_out,
                                       input logic [ByteW-1:0] dat);
    fault_t f;
    if (sel_in > NULL_SEL)       f = FAULT_INPUT;
    else if (sel_out > NULL_SEL) f = FAULT_OUTPUT;
    else if (dat > DATA_ONE)     f = FAULT_DATA;
    else                         f = FAULT_NONE;
    return f;
  endfunction

  // input | output<<3 | data<<6
  function automatic logic [CtlW-1:0] ctl_pack(input logic [ByteW-1:0] sel_in,
                                               input logic [ByteW-1:0] sel_out,
                                               input logic [ByteW-1:0] dat);
    return {dat[0], sel_out[2:0], sel_in[2:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/obe_ifs.sv =====
// ----------------------------------------------------------------------------
// obe_ifs
// Valid/ready channels for instruction requests and encoded words.
// ----------------------------------------------------------------------------
`default_nettype none

interface obe_instr_if;
  logic           valid;
  logic           ready;
  obe_pkg::instr_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface obe_word_if;
  logic          valid;
  logic          ready;
  obe_pkg::word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/one_bit_instruction_encoder.sv =====
// ----------------------------------------------------------------------------
// one_bit_instruction_encoder
// Turns one resolved instruction into a two-way instruction word.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-------------
//  instr   | in  | action, four operand bytes, here_address  | valid/ready
//  word    | out | false/true control, false/true next, fault| valid/ready
//
//  Two register stages: an input register, then the encode logic, then the
//  result register. One request per cycle sustained while the result is taken.
//  Both stages advance whenever the result register is empty or taken. A held
//  result stalls both; the input register still takes one request while
//  empty, then instr ready stays low until the result is taken.
//  rst (synchronous) empties both stages; no other state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "one_bit_instruction_encoder_defines.svh"

module one_bit_instruction_encoder (
  input  logic         clk,
  input  logic         rst,
  obe_instr_if.sink    instr,
  obe_word_if.source   word
);
  import obe_pkg::*;

  // stage 1: captured request
  logic   s1_valid;
  instr_t s1_req;
  // stage 2: result register
  logic   out_valid;
  word_t  out_word;

  logic   s2_ready;
  word_t  word_next;

  assign s2_ready    = !out_valid || word.ready;
  assign instr.ready = !s1_valid || s2_ready;
  assign word.valid  = out_valid;
  assign word.data   = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (instr.ready) s1_valid  <= instr.valid;
      if (s2_ready)    out_valid <= s1_valid;
    end
    if (instr.valid && instr.ready) s1_req   <= instr.data;
    if (s2_ready && s1_valid)       out_word <= word_next;
  end

  // --------------------------------------------------------------------------
  // Encode. Each branch byte is described by (input, output, data) selectors;
  // the default (7,7,1) packs to 127. mirror copies the false byte to the
  // true byte. true_first marks CSETB/CCLRB, whose true byte is checked first.
  // --------------------------------------------------------------------------
  logic [ByteW-1:0] p1, p2, p3, p4, here, plus1, plus2, minus1;
  logic [ByteW-1:0] f_in, f_out, f_dat, t_in, t_out, t_dat;
  logic [ByteW-1:0] fn, tn;
  logic             mirror, true_first;
  fault_t           f_chk, t_chk, first_chk, second_chk, fault;

  assign p1     = s1_req.first_operand;
  assign p2     = s1_req.second_operand;
  assign p3     = s1_req.third_operand;
  assign p4     = s1_req.fourth_operand;
  assign here   = s1_req.here_address;
  assign plus1  = here + 8'd1;
  assign plus2  = here + 8'd2;
  assign minus1 = here - 8'd1;

  always_comb begin
    f_in = NULL_SEL;  f_out = NULL_SEL;  f_dat = DATA_ONE;
    t_in = NULL_SEL;  t_out = NULL_SEL;  t_dat = DATA_ONE;
    fn = plus1;
    tn = plus1;
    mirror     = 1'b0;
    true_first = 1'b0;
    unique case (act_t'(s1_req.action))
      ACT_HALT: begin
        f_dat = DATA_ZERO; mirror = 1'b1; fn = here; tn = here;
      end
      ACT_SETB:    begin f_out = p1; mirror = 1'b1; end
      ACT_SETBJMP: begin f_out = p1; mirror = 1'b1; fn = p2; tn = p2; end
      ACT_CSETB:   begin t_out = p1; f_out = p2; true_first = 1'b1; end
      ACT_CLRB:    begin f_out = p1; f_dat = DATA_ZERO; mirror = 1'b1; end
      ACT_CLRBJMP: begin
        f_out = p1; f_dat = DATA_ZERO; mirror = 1'b1; fn = p2; tn = p2;
      end
      ACT_CCLRB: begin
        t_out = p1; t_dat = DATA_ZERO; f_out = p2; f_dat = DATA_ZERO;
        true_first = 1'b1;
      end
      ACT_OUTIN: begin
        f_in = p2; f_out = p1; f_dat = DATA_ZERO; t_in = p2; t_out = p1;
      end
      ACT_OUTINJMP: begin
        f_in = p2; f_out = p1; f_dat = DATA_ZERO; t_in = p2; t_out = p1;
        fn = p3; tn = p3;
      end
      ACT_OUTV:    begin f_out = p1; f_dat = p2; mirror = 1'b1; end
      ACT_OUTVJMP: begin f_out = p1; f_dat = p2; mirror = 1'b1; fn = p3; tn = p3; end
      ACT_OUT:     begin f_out = p1; f_dat = DATA_ZERO; t_out = p1; end
      ACT_OUTI:    begin f_out = p1; t_out = p1; t_dat = DATA_ZERO; end
      ACT_OUTIJMP: begin
        f_out = p1; t_out = p1; t_dat = DATA_ZERO; fn = p2; tn = p2;
      end
      ACT_OUTJMP: begin
        f_out = p1; f_dat = DATA_ZERO; t_out = p1; fn = p2; tn = p2;
      end
      ACT_COUTF:  begin f_out = p1; f_dat = p2; t_out = p3; t_dat = p4; end
      ACT_IN:     begin f_in = p1; mirror = 1'b1; end
      ACT_INJMP:  begin f_in = p1; mirror = 1'b1; fn = p2; tn = p2; end
      ACT_INJPS:  begin f_in = p1; mirror = 1'b1; tn = p2; end
      ACT_INJPC:  begin f_in = p1; mirror = 1'b1; fn = p2; end
      ACT_CINF:   begin f_in = p1; t_in = p2; end
      ACT_JMP:    begin fn = p1; tn = p1; end
      ACT_JPS:    tn = p1;
      ACT_JPC:    fn = p1;
      ACT_FORKF:  begin fn = p1; tn = p2; end
      ACT_FORKI:  begin f_in = p1; mirror = 1'b1; fn = p2; tn = p3; end
      ACT_WAITIS: begin f_in = p1; mirror = 1'b1; fn = here; end
      ACT_WAITIC: begin f_in = p1; mirror = 1'b1; tn = here; end
      ACT_SKIPIC: begin f_in = p1; mirror = 1'b1; fn = plus2; end
      ACT_SKIPIS: begin f_in = p1; mirror = 1'b1; tn = plus2; end
      ACT_SKIPFC: fn = plus2;
      ACT_SKIPFS: tn = plus2;
      ACT_REPTIC: begin f_in = p1; mirror = 1'b1; fn = minus1; end
      ACT_REPTIS: begin f_in = p1; mirror = 1'b1; tn = minus1; end
      ACT_REPTFC: fn = minus1;
      ACT_REPTFS: tn = minus1;
      default: ; // NOP and unused codes: default word
    endcase
    if (mirror) begin
      t_in  = f_in;
      t_out = f_out;
      t_dat = f_dat;
    end
  end

  // first failing check wins, in build order
  assign f_chk      = ctl_check(f_in, f_out, f_dat);
  assign t_chk      = ctl_check(t_in, t_out, t_dat);
  assign first_chk  = true_first ? t_chk : f_chk;
  assign second_chk = true_first ? f_chk : t_chk;
  assign fault      = (first_chk != FAULT_NONE) ? first_chk : second_chk;

  always_comb begin
    word_next.fault = fault;
    if (fault != FAULT_NONE) begin
      word_next.false_control = '0;
      word_next.true_control  = '0;
      word_next.false_next    = '0;
      word_next.true_next     = '0;
    end else begin
      word_next.false_control = ctl_pack(f_in, f_out, f_dat);
      word_next.true_control  = ctl_pack(t_in, t_out, t_dat);
      word_next.false_next    = fn;
      word_next.true_next     = tn;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `OBE_ASSERT_NOW(a_fault_zeroes,
    out_valid && (out_word.fault != FAULT_NONE),
    (out_word.false_control == '0) && (out_word.true_control == '0) &&
    (out_word.false_next == '0) && (out_word.true_next == '0),
    "faulted word not cleared")
  `OBE_ASSERT_NEXT(a_stage_moves, s1_valid && s2_ready, out_valid,
    "stage 1 request lost on advance")
  `OBE_ASSERT_NOW(a_no_overwrite, instr.valid && instr.ready && s1_valid,
    s2_ready, "input register overwritten while held")
  `OBE_ASSERT_NEXT(a_held_result, out_valid && !word.ready,
    out_valid && $stable(out_word), "held result changed")

endmodule

`default_nettype wire
